>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk with arst_n low as disable
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fsh_pkg.sv
// shared types and constants of the frequency spectrum histogram
package fsh_pkg;

	localparam int DEF_MAX_BINS  = 16;
	localparam int DEF_MAX_TYPES = 4;

	localparam int POS_W      = 40;
	localparam int REF_W      = 32;
	localparam int TYPE_IN_W  = 2;
	localparam int OUT_TYPE_W = 2;
	localparam int OUT_BIN_W  = 4;
	localparam int PROP_W     = 17;
	localparam int FRAC_W     = 16;
	localparam int COUNT_W    = 32;
	localparam int GENOME_W   = 32;
	localparam int BINCNT_W   = 5;
	localparam int TYPECNT_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [PROP_W-1:0] PROP_ONE = PROP_W'(1) << FRAC_W;

	localparam logic OP_TALLY  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIN_COUNT    = 3'd0,
		REG_TYPE_COUNT   = 3'd1,
		REG_GENOME_TOTAL = 3'd2,
		REG_RANGE_ENABLE = 3'd3,
		REG_RANGE_FIRST  = 3'd4,
		REG_RANGE_LAST   = 3'd5
	} fsh_reg_t;

	localparam logic [BINCNT_W-1:0]  RST_BIN_COUNT    = 5'd10;
	localparam logic [TYPECNT_W-1:0] RST_TYPE_COUNT   = 3'd1;
	localparam logic [GENOME_W-1:0]  RST_GENOME_TOTAL = 32'd1;

endpackage

>>> hw/rtl/fsh_if.sv
// valid/ready channels of the frequency spectrum histogram
interface fsh_item_if import fsh_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [POS_W-1:0]     site_position;
	logic [REF_W-1:0]     ref_count;
	logic [TYPE_IN_W-1:0] type_index;

	modport source(output valid, opcode, site_position, ref_count, type_index, input ready);
	modport sink(input valid, opcode, site_position, ref_count, type_index, output ready);
endinterface

interface fsh_result_if import fsh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OUT_TYPE_W-1:0] out_type;
	logic [OUT_BIN_W-1:0]  out_bin;
	logic [PROP_W-1:0]     proportion;
	logic                  last;

	modport source(output valid, out_type, out_bin, proportion, last, input ready);
	modport sink(input valid, out_type, out_bin, proportion, last, output ready);
endinterface

interface fsh_cfg_if import fsh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/frequency_spectrum_histogram_unit.sv
// top level of the frequency spectrum histogram
// Keeps a saturating 32-bit count per (mutation type, frequency bin) in a
// MAX_TYPES*MAX_BINS entry memory. A tally item finds its bin with one
// shared restoring compare/subtract unit, then does a read-modify-write of
// the count. A filtered or dropped tally is consumed in ST_IDLE; any other
// tally runs the divide on the shared unit, then the bin address, the
// registered memory read and the write-back of the count. A finish
// item sums each type bin by bin, then divides each bin count
// by the type total in 17 steps on the same unit (skipped when the total
// is zero; a bin waits while its result is not taken), and ends
// with a clearing sweep over all MAX_TYPES*MAX_BINS entries. The same sweep runs
// after reset; the item channel is not ready during any of this, while
// configuration writes are always taken.
`include "assert_macros.svh"

module frequency_spectrum_histogram_unit import fsh_pkg::*; #(
	parameter int MAX_BINS  = DEF_MAX_BINS,
	parameter int MAX_TYPES = DEF_MAX_TYPES
) (
	input  logic          clk,
	input  logic          arst_n,
	fsh_cfg_if.sink       cfg,
	fsh_item_if.sink      item,
	fsh_result_if.source  result
);

	localparam int DEPTH = MAX_TYPES * MAX_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BIW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int TIW   = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
	localparam int BNW   = $clog2(MAX_BINS + 1);
	localparam int TNW   = $clog2(MAX_TYPES + 1);
	localparam int QW    = BNW;
	localparam int QDW   = (QW + 1 > PROP_W) ? QW + 1 : PROP_W;
	localparam int ITMAX = (QW > FRAC_W) ? QW : FRAC_W;
	localparam int ITW   = $clog2(ITMAX + 1);
	localparam int TTW   = COUNT_W + BNW;
	localparam int UW    = TTW + FRAC_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_T_ADDR,
		ST_T_READ,
		ST_T_WRITE,
		ST_F_SUM_RD,
		ST_F_SUM_ACC,
		ST_F_DIV_RD,
		ST_F_DIV_LOAD,
		ST_F_EMIT,
		ST_CLEAR
	} state_t;

	// configuration registers
	logic [BINCNT_W-1:0]  bin_count_q;
	logic [TYPECNT_W-1:0] type_count_q;
	logic [GENOME_W-1:0]  genome_total_q;
	logic                 range_enable_q;
	logic [POS_W-1:0]     range_first_q;
	logic [POS_W-1:0]     range_last_q;

	state_t               state_q;
	logic                 finish_mode_q;
	logic [TIW-1:0]       t_q;
	logic [BIW-1:0]       b_q;
	logic [AW-1:0]        clr_q;
	logic [TTW-1:0]       total_q;
	logic [UW-1:0]        rem_q;
	logic [UW-1:0]        dvs_q;
	logic [QDW-1:0]       q_q;
	logic [ITW-1:0]       iter_q;
	logic [COUNT_W-1:0]   rd_data_q;

	logic                  out_valid_q;
	logic [OUT_TYPE_W-1:0] out_type_q;
	logic [OUT_BIN_W-1:0]  out_bin_q;
	logic [PROP_W-1:0]     proportion_q;
	logic                  last_q;

	logic [COUNT_W-1:0] mem [DEPTH];

	logic [BNW-1:0]      eff_bins;
	logic [TNW-1:0]      eff_types;
	logic [GENOME_W-1:0] genome_eff;
	logic                skip;
	logic [TTW-1:0]      tally_prod;
	logic                ge;
	logic [UW-1:0]       diff;
	logic [AW-1:0]       addr_tb;
	logic [AW-1:0]       mem_addr;
	logic                mem_we;
	logic [COUNT_W-1:0]  mem_wdata;
	logic                last_t;
	logic                last_b;
	logic                out_free;

	always_comb begin
		if (bin_count_q == '0) begin
			eff_bins = BNW'(1);
		end else if (32'(bin_count_q) > 32'(MAX_BINS)) begin
			eff_bins = BNW'(MAX_BINS);
		end else begin
			eff_bins = BNW'(bin_count_q);
		end
		if (type_count_q == '0) begin
			eff_types = TNW'(1);
		end else if (32'(type_count_q) > 32'(MAX_TYPES)) begin
			eff_types = TNW'(MAX_TYPES);
		end else begin
			eff_types = TNW'(type_count_q);
		end
	end

	assign genome_eff = (genome_total_q == '0) ? GENOME_W'(1) : genome_total_q;

	assign skip = (range_enable_q && (item.site_position < range_first_q ||
		item.site_position > range_last_q)) ||
		(32'(item.type_index) >= 32'(eff_types));

	// product is below 2^TTW since the bin count fits in BNW bits
	assign tally_prod = {{BNW{1'b0}}, item.ref_count} * {{COUNT_W{1'b0}}, eff_bins};

	// shared compare/subtract unit
	assign ge   = rem_q >= dvs_q;
	assign diff = rem_q - dvs_q;

	assign addr_tb  = AW'(32'(t_q) * 32'(MAX_BINS) + 32'(b_q));
	assign mem_addr = (state_q == ST_CLEAR) ? clr_q : addr_tb;
	assign mem_we   = (state_q == ST_T_WRITE) || (state_q == ST_CLEAR);
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 :
		((rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1);

	assign last_t   = t_q == TIW'(eff_types - 1'b1);
	assign last_b   = b_q == BIW'(eff_bins - 1'b1);
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_addr];
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q    <= RST_BIN_COUNT;
			type_count_q   <= RST_TYPE_COUNT;
			genome_total_q <= RST_GENOME_TOTAL;
			range_enable_q <= 1'b0;
			range_first_q  <= '0;
			range_last_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BIN_COUNT: begin
					bin_count_q <= cfg.data[BINCNT_W-1:0];
				end
				REG_TYPE_COUNT: begin
					type_count_q <= cfg.data[TYPECNT_W-1:0];
				end
				REG_GENOME_TOTAL: begin
					genome_total_q <= cfg.data[GENOME_W-1:0];
				end
				REG_RANGE_ENABLE: begin
					range_enable_q <= cfg.data[0];
				end
				REG_RANGE_FIRST: begin
					range_first_q <= cfg.data[POS_W-1:0];
				end
				REG_RANGE_LAST: begin
					range_last_q <= cfg.data[POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			finish_mode_q <= 1'b0;
			t_q           <= '0;
			b_q           <= '0;
			clr_q         <= '0;
			total_q       <= '0;
			rem_q         <= '0;
			dvs_q         <= '0;
			q_q           <= '0;
			iter_q        <= '0;
			out_valid_q   <= 1'b0;
			out_type_q    <= '0;
			out_bin_q     <= '0;
			proportion_q  <= '0;
			last_q        <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && state_q != ST_F_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						t_q     <= '0;
						b_q     <= '0;
						total_q <= '0;
						if (item.opcode == OP_FINISH) begin
							finish_mode_q <= 1'b1;
							state_q       <= ST_F_SUM_RD;
						end else if (!skip) begin
							finish_mode_q <= 1'b0;
							t_q    <= TIW'(item.type_index);
							rem_q  <= UW'(tally_prod);
							dvs_q  <= UW'({genome_eff, {QW{1'b0}}});
							q_q    <= '0;
							iter_q <= ITW'(QW);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (ge) begin
						rem_q <= diff;
					end
					q_q   <= {q_q[QDW-2:0], ge};
					dvs_q <= dvs_q >> 1;
					if (iter_q == '0) begin
						state_q <= finish_mode_q ? ST_F_EMIT : ST_T_ADDR;
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				ST_T_ADDR: begin
					// quotient past the last bin lands in the last bin
					if (q_q >= QDW'(eff_bins)) begin
						b_q <= BIW'(eff_bins - 1'b1);
					end else begin
						b_q <= BIW'(q_q);
					end
					state_q <= ST_T_READ;
				end
				ST_T_READ: begin
					state_q <= ST_T_WRITE;
				end
				ST_T_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_F_SUM_RD: begin
					state_q <= ST_F_SUM_ACC;
				end
				ST_F_SUM_ACC: begin
					total_q <= total_q + TTW'(rd_data_q);
					if (last_b) begin
						b_q     <= '0;
						state_q <= ST_F_DIV_RD;
					end else begin
						b_q     <= b_q + 1'b1;
						state_q <= ST_F_SUM_RD;
					end
				end
				ST_F_DIV_RD: begin
					state_q <= ST_F_DIV_LOAD;
				end
				ST_F_DIV_LOAD: begin
					q_q <= '0;
					if (total_q == '0) begin
						state_q <= ST_F_EMIT;
					end else begin
						// rounded share: (count * 2^16 + total/2) / total
						rem_q  <= UW'({rd_data_q, {FRAC_W{1'b0}}}) + UW'(total_q >> 1);
						dvs_q  <= {total_q, {FRAC_W{1'b0}}};
						iter_q <= ITW'(FRAC_W);
						state_q <= ST_DIV;
					end
				end
				ST_F_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_type_q   <= OUT_TYPE_W'(t_q);
						out_bin_q    <= OUT_BIN_W'(b_q);
						proportion_q <= q_q[PROP_W-1:0];
						last_q       <= last_t && last_b;
						if (!last_b) begin
							b_q     <= b_q + 1'b1;
							state_q <= ST_F_DIV_RD;
						end else if (!last_t) begin
							t_q     <= t_q + 1'b1;
							b_q     <= '0;
							total_q <= '0;
							state_q <= ST_F_SUM_RD;
						end else begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end
					end else if (out_valid_q && result.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item.ready        = state_q == ST_IDLE;
	assign result.valid      = out_valid_q;
	assign result.out_type   = out_type_q;
	assign result.out_bin    = out_bin_q;
	assign result.proportion = proportion_q;
	assign result.last       = last_q;

	`ASSERT_NEXT(a_finish_busy, item.valid && item.ready && item.opcode == OP_FINISH, !item.ready, "finish transfer left the block ready")
	`ASSERT_IMPL(a_prop_range, state_q == ST_F_EMIT && total_q != '0, q_q <= QDW'(PROP_ONE), "share above one")
	`ASSERT_NEXT(a_last_clears, state_q == ST_F_EMIT && out_free && last_t && last_b, state_q == ST_CLEAR, "final result not followed by clear")
	`ASSERT_IMPL(a_bin_clamp, state_q == ST_T_READ, 32'(b_q) < 32'(eff_bins), "tally bin past the last bin")

endmodule

>>> tb/tb_frequency_spectrum_histogram_unit.sv
// self-checking testbench for the frequency spectrum histogram unit
module tb_frequency_spectrum_histogram_unit;
	import fsh_pkg::*;

	localparam int NBINS      = DEF_MAX_BINS;
	localparam int NTYPES     = DEF_MAX_TYPES;
	localparam int SETTLE     = 100;
	localparam int LIMIT      = 5000000;
	localparam int RAND_ITEMS = 430;
	localparam int LONG_HOLD  = 400;

	typedef struct packed {
		logic [OUT_TYPE_W-1:0] typ;
		logic [OUT_BIN_W-1:0]  bin;
		logic [PROP_W-1:0]     share;
		logic                  last;
	} share_t;

	typedef enum logic [1:0] {ROW_REG, ROW_TALLY, ROW_FINISH} row_kind_t;
	typedef enum logic [1:0] {SHARE_MODEL, SHARE_ZERO, SHARE_ONE_HOT} share_chk_t;

	// data holds the register value or the site position
	typedef struct {
		row_kind_t             kind;
		fsh_reg_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic [REF_W-1:0]      refc;
		logic [TYPE_IN_W-1:0]  typ;
		share_chk_t            chk;
		int                    hot;
	} row_t;

	row_t dir_rows [45] = '{
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_ZERO, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_ONE_HOT, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_ONE_HOT, 9},
		'{ROW_REG, REG_GENOME_TOTAL, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_BIN_COUNT, 16, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_TYPE_COUNT, 4, 0, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 12345, 1, 3, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 40'hFF_FFFF_FFFF, 0, 2, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_TYPE_COUNT, 2, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_BIN_COUNT, 1, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_GENOME_TOTAL, 40'hFFFF_FFFF, 0, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 7, 5, 3, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 7, 32'hFFFF_FFFF, 1, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_BIN_COUNT, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_TYPE_COUNT, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 3, 3, 1, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 9, 9, 0, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_ONE_HOT, 0},
		'{ROW_REG, REG_BIN_COUNT, 31, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_TYPE_COUNT, 7, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_GENOME_TOTAL, 100, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_RANGE_FIRST, 1000, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_RANGE_LAST, 2000, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_RANGE_ENABLE, 1, 0, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 999, 50, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 1000, 50, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 2000, 99, 3, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 1500, 100, 2, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_RANGE_FIRST, 40'hFF_FFFF_FFFF, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_RANGE_LAST, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 40'h80_0000_0000, 1, 0, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_ZERO, 0},
		'{ROW_REG, REG_RANGE_ENABLE, 0, 0, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_GENOME_TOTAL, 16, 0, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 5, 15, 0, SHARE_MODEL, 0},
		'{ROW_TALLY, REG_BIN_COUNT, 6, 1, 0, SHARE_MODEL, 0},
		'{ROW_REG, REG_BIN_COUNT, 4, 0, 0, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_ONE_HOT, 1},
		'{ROW_REG, REG_BIN_COUNT, 16, 0, 0, SHARE_MODEL, 0},
		'{ROW_FINISH, REG_BIN_COUNT, 0, 0, 0, SHARE_ZERO, 0}
	};

	logic clk;
	logic arst_n;

	fsh_cfg_if    cfg_bus();
	fsh_item_if   item_bus();
	fsh_result_if res_bus();

	frequency_spectrum_histogram_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.item  (item_bus),
		.result(res_bus)
	);

	// predictor state and its copy of the registers
	logic [COUNT_W-1:0]   spec_counts [NTYPES*NBINS];
	logic [BINCNT_W-1:0]  cur_bins;
	logic [TYPECNT_W-1:0] cur_types;
	logic [GENOME_W-1:0]  cur_genomes;
	logic                 cur_range_on;
	logic [POS_W-1:0]     cur_lo;
	logic [POS_W-1:0]     cur_hi;

	share_t share_q [$];

	int errors      = 0;
	int n_counted   = 0;
	int n_skipped   = 0;
	int n_finish    = 0;
	int n_results   = 0;
	int n_settings  = 0;
	int hold_cycles = 0;
	bit burst_mode  = 1'b0;
	longint unsigned cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int eff_bins();
		if (cur_bins == 0) return 1;
		if (cur_bins > NBINS) return NBINS;
		return int'(cur_bins);
	endfunction

	function automatic int eff_types();
		if (cur_types == 0) return 1;
		if (cur_types > NTYPES) return NTYPES;
		return int'(cur_types);
	endfunction

	function automatic void set_reg(fsh_reg_t idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_BIN_COUNT:    cur_bins = d[BINCNT_W-1:0];
			REG_TYPE_COUNT:   cur_types = d[TYPECNT_W-1:0];
			REG_GENOME_TOTAL: cur_genomes = d[GENOME_W-1:0];
			REG_RANGE_ENABLE: cur_range_on = d[0];
			REG_RANGE_FIRST:  cur_lo = d[POS_W-1:0];
			REG_RANGE_LAST:   cur_hi = d[POS_W-1:0];
			default: ;
		endcase
	endfunction

	// returns 1 when the site lands in a count
	function automatic bit tally_site(logic [POS_W-1:0] pos, logic [REF_W-1:0] refc,
			logic [TYPE_IN_W-1:0] typ);
		longint unsigned g;
		longint unsigned b;
		int slot;
		if (cur_range_on && (pos < cur_lo || pos > cur_hi)) return 1'b0;
		if (int'(typ) >= eff_types()) return 1'b0;
		g = (cur_genomes == 0) ? 64'(1) : 64'(cur_genomes);
		b = (64'(refc) * 64'(eff_bins())) / g;
		if (b >= 64'(eff_bins())) b = 64'(eff_bins() - 1);
		slot = int'(typ) * NBINS + int'(b);
		if (spec_counts[slot] != '1) spec_counts[slot]++;
		return 1'b1;
	endfunction

	function automatic void close_spectrum(bit keep);
		longint unsigned total;
		longint unsigned c;
		longint unsigned p;
		share_t s;
		int nt;
		int nb;
		nt = eff_types();
		nb = eff_bins();
		for (int t = 0; t < nt; t++) begin
			total = 0;
			for (int b = 0; b < nb; b++) total += 64'(spec_counts[t*NBINS+b]);
			for (int b = 0; b < nb; b++) begin
				c = 64'(spec_counts[t*NBINS+b]);
				p = (total == 0) ? 64'(0) : ((c << FRAC_W) + (total >> 1)) / total;
				s.typ = OUT_TYPE_W'(t);
				s.bin = OUT_BIN_W'(b);
				s.share = p[PROP_W-1:0];
				s.last = (t == nt - 1) && (b == nb - 1);
				if (keep) share_q.push_back(s);
			end
		end
		foreach (spec_counts[i]) spec_counts[i] = '0;
	endfunction

	// shares typed in from the table: all zero, or type 0 entirely in one bin
	function automatic void typed_shares(share_chk_t chk, int hot);
		share_t s;
		int nt;
		int nb;
		nt = eff_types();
		nb = eff_bins();
		for (int t = 0; t < nt; t++) begin
			for (int b = 0; b < nb; b++) begin
				s.typ = OUT_TYPE_W'(t);
				s.bin = OUT_BIN_W'(b);
				s.share = (chk == SHARE_ONE_HOT && t == 0 && b == hot) ? PROP_ONE : '0;
				s.last = (t == nt - 1) && (b == nb - 1);
				share_q.push_back(s);
			end
		end
	endfunction

	function automatic logic [POS_W-1:0] rand_site();
		return POS_W'({$urandom, $urandom});
	endfunction

	function automatic void report(string field, logic [PROP_W-1:0] want_v,
			logic [PROP_W-1:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
	endfunction

	// drain outstanding results, then give an in-flight tally or clearing sweep time to end
	task automatic settle();
		item_bus.valid <= 1'b0;
		cfg_bus.valid <= 1'b0;
		while (share_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		n_settings++;
	endtask

	task automatic write_reg(fsh_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= d;
		do @(posedge clk); while (!cfg_bus.ready);
		set_reg(idx, d);
	endtask

	task automatic send_item(logic op, logic [POS_W-1:0] pos, logic [REF_W-1:0] refc,
			logic [TYPE_IN_W-1:0] typ, share_chk_t chk = SHARE_MODEL, int hot = 0);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.opcode <= op;
		item_bus.site_position <= pos;
		item_bus.ref_count <= refc;
		item_bus.type_index <= typ;
		do @(posedge clk); while (!item_bus.ready);
		if (op == OP_TALLY) begin
			if (tally_site(pos, refc, typ)) n_counted++;
			else n_skipped++;
		end else begin
			n_finish++;
			n_counted++;
			if (chk != SHARE_MODEL) typed_shares(chk, hot);
			close_spectrum(chk == SHARE_MODEL);
		end
	endtask

	task automatic random_tally();
		longint unsigned g;
		longint unsigned span;
		logic [POS_W-1:0] pos;
		logic [REF_W-1:0] refc;
		logic [TYPE_IN_W-1:0] typ;
		g = (cur_genomes == 0) ? 64'(1) : 64'(cur_genomes);
		// mostly counts up to the genome total so that hits spread over the bins
		refc = ($urandom_range(0, 9) < 7) ? REF_W'($urandom_range(0, 32'(g))) : $urandom;
		if (cur_range_on && cur_lo <= cur_hi && $urandom_range(0, 9) < 8) begin
			span = 64'(cur_hi) - 64'(cur_lo) + 1;
			pos = cur_lo + POS_W'({$urandom, $urandom} % span);
		end else
			pos = rand_site();
		if ($urandom_range(0, 9) < 8) typ = TYPE_IN_W'($urandom_range(0, eff_types() - 1));
		else typ = TYPE_IN_W'($urandom_range(0, 3));
		send_item(OP_TALLY, pos, refc, typ);
	endtask

	initial begin : result_sink
		share_t want;
		int stall;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else
				stall = burst_mode ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
			n_results++;
			if (share_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual type %0d bin %0d proportion %0d last %0b",
					$time, res_bus.out_type, res_bus.out_bin, res_bus.proportion, res_bus.last);
			end else begin
				want = share_q.pop_front();
				if (res_bus.out_type !== want.typ)
					report("out_type", PROP_W'(want.typ), PROP_W'(res_bus.out_type));
				if (res_bus.out_bin !== want.bin)
					report("out_bin", PROP_W'(want.bin), PROP_W'(res_bus.out_bin));
				if (res_bus.proportion !== want.share)
					report("proportion", want.share, res_bus.proportion);
				if (res_bus.last !== want.last)
					report("last", PROP_W'(want.last), PROP_W'(res_bus.last));
			end
		end
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t: timeout after %0d cycles, %0d results outstanding",
			$time, cycle_cnt, share_q.size());
		$display("tb_frequency_spectrum_histogram_unit: errors");
		$finish;
	end

	initial begin : stimulus
		row_kind_t prev;
		int base;
		int phase;
		int n;
		bit squeeze;
		logic [BINCNT_W-1:0] bins_v;
		logic [GENOME_W-1:0] genomes_v;
		logic [POS_W-1:0] lo_v;
		logic [POS_W:0] hi_wide;

		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_BIN_COUNT;
		cfg_bus.data <= '0;
		item_bus.valid <= 1'b0;
		item_bus.opcode <= OP_TALLY;
		item_bus.site_position <= '0;
		item_bus.ref_count <= '0;
		item_bus.type_index <= '0;
		foreach (spec_counts[i]) spec_counts[i] = '0;
		cur_bins = RST_BIN_COUNT;
		cur_types = RST_TYPE_COUNT;
		cur_genomes = RST_GENOME_TOTAL;
		cur_range_on = 1'b0;
		cur_lo = '0;
		cur_hi = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		prev = ROW_TALLY;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				if (prev != ROW_REG) settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				if (prev == ROW_REG) cfg_bus.valid <= 1'b0;
				send_item(dir_rows[i].kind == ROW_FINISH ? OP_FINISH : OP_TALLY,
					dir_rows[i].data[POS_W-1:0], dir_rows[i].refc, dir_rows[i].typ,
					dir_rows[i].chk, dir_rows[i].hot);
			end
			prev = dir_rows[i].kind;
		end

		// random phases: one register setting, then two rounds of tallies closed by a finish
		base = n_counted + n_skipped;
		phase = 0;
		while (n_counted + n_skipped < base + RAND_ITEMS) begin
			settle();
			squeeze = (phase % 8 == 1);
			burst_mode = !squeeze && ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: bins_v = '0;
				1: bins_v = BINCNT_W'(1);
				2: bins_v = BINCNT_W'(NBINS);
				3: bins_v = BINCNT_W'($urandom_range(NBINS + 1, 31));
				default: bins_v = BINCNT_W'($urandom_range(1, NBINS));
			endcase
			case ($urandom_range(0, 9))
				0: genomes_v = '0;
				1: genomes_v = '1;
				2, 3: genomes_v = $urandom;
				4: genomes_v = $urandom_range(1, 1000);
				default: genomes_v = $urandom_range(1, 64);
			endcase
			lo_v = rand_site();
			case ($urandom_range(0, 3))
				0: hi_wide = {1'b0, rand_site()};
				1: hi_wide = {1'b0, lo_v};
				default: hi_wide = {1'b0, lo_v} + (POS_W+1)'($urandom_range(0, 1 << 20));
			endcase
			if (hi_wide[POS_W]) hi_wide = {1'b0, {POS_W{1'b1}}};
			write_reg(REG_BIN_COUNT, squeeze ? CFG_DATA_W'(NBINS) : CFG_DATA_W'(bins_v));
			write_reg(REG_TYPE_COUNT,
				squeeze ? CFG_DATA_W'(NTYPES) : CFG_DATA_W'($urandom_range(0, 7)));
			write_reg(REG_GENOME_TOTAL, CFG_DATA_W'(genomes_v));
			write_reg(REG_RANGE_FIRST, lo_v);
			write_reg(REG_RANGE_LAST, hi_wide[POS_W-1:0]);
			write_reg(REG_RANGE_ENABLE,
				($urandom_range(0, 9) < 4) ? CFG_DATA_W'(1) : CFG_DATA_W'(0));
			cfg_bus.valid <= 1'b0;
			for (int round = 0; round < 2; round++) begin
				n = squeeze ? $urandom_range(4, 12) : $urandom_range(0, 12);
				repeat (n) random_tally();
				// result side holds off while the next round keeps offering tallies
				if (squeeze && round == 0) hold_cycles = LONG_HOLD;
				send_item(OP_FINISH, rand_site(), REF_W'($urandom),
					TYPE_IN_W'($urandom_range(0, 3)));
			end
			phase++;
		end

		item_bus.valid <= 1'b0;
		while (share_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d counted tallies, %0d filtered or dropped, %0d finishes, %0d settings",
			n_counted - n_finish, n_skipped, n_finish, n_settings);
		$display("%0d results compared, %0d mismatches", n_results, errors);
		if (errors == 0)
			$display("tb_frequency_spectrum_histogram_unit: clean");
		else
			$display("tb_frequency_spectrum_histogram_unit: errors");
		$finish;
	end

endmodule
